/* hdl/tsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants and types for the texture slot replacement unit.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TEX_W         = 32;
    localparam int SLOT_OUT_W    = 4;

    typedef struct packed {
        logic en;
        logic hit;
    } t_upd_ctrl;

endpackage

/* hdl/texture_slot_replacement_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_slot_replacement_unit
// Binds texture identifiers to slots with a transpose priority order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / i_texture_id / o_stall carries one bind request
//   per transfer. Output channel o_valid / o_slot_index / o_hit /
//   o_evicted_valid / o_evicted_texture / i_stall returns one result per
//   request, in order.
//   From input transfer to result valid, the request sits in the input
//   register, then a single pass of tag compare, order update and slot
//   refill loads the result register when it is free or being taken.
//   Throughput is one request per cycle when not stalled; the slot table
//   and order update for a request are committed in the cycle it moves
//   to the result register, so the next request sees them at once.
//   A zero identifier gives an all-zero result and leaves the state alone.
//   Reset empties every slot and sets the order to ascending slot numbers;
//   both channels come up empty.
//   When the receiver stalls, the result holds; the input register still
//   takes one more request, then o_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module texture_slot_replacement_unit #(
    parameter int NUM_SLOTS = tsr_pkg::NUM_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [tsr_pkg::TEX_W-1:0]      i_texture_id,
    output logic                           o_stall,
    output logic                           o_valid,
    output logic [tsr_pkg::SLOT_OUT_W-1:0] o_slot_index,
    output logic                           o_hit,
    output logic                           o_evicted_valid,
    output logic [tsr_pkg::TEX_W-1:0]      o_evicted_texture,
    input  logic                           i_stall
);
    import tsr_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic                  r_in_valid;
    logic [TEX_W-1:0]      r_in_tex;
    logic                  r_out_valid;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic                  r_hit;
    logic                  r_ev_valid;
    logic [TEX_W-1:0]      r_ev_tex;

    logic                  advance;
    logic                  tex_ok;
    logic                  tbl_hit;
    logic [IDX_W-1:0]      found;
    logic [IDX_W-1:0]      victim;
    logic [TEX_W-1:0]      victim_tex;
    logic [IDX_W-1:0]      sel_slot;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
    t_upd_ctrl             upd;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign tex_ok  = (r_in_tex != '0);

    assign upd.en  = advance && tex_ok;
    assign upd.hit = tbl_hit;

    assign sel_slot = tbl_hit ? found : victim;
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, sel_slot};

    tsr_slot_table #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_table (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_texture_id     (r_in_tex),
        .i_victim         (victim),
        .i_upd            (upd),
        .o_hit            (tbl_hit),
        .o_found          (found),
        .o_victim_texture (victim_tex)
    );

    tsr_priority_list #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_order (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (upd),
        .i_slot   (found),
        .o_victim (victim)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_tex <= i_texture_id;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (!tex_ok) begin
                r_slot     <= '0;
                r_hit      <= 1'b0;
                r_ev_valid <= 1'b0;
                r_ev_tex   <= '0;
            end else if (tbl_hit) begin
                r_slot     <= slot_ext[SLOT_OUT_W-1:0];
                r_hit      <= 1'b1;
                r_ev_valid <= 1'b0;
                r_ev_tex   <= '0;
            end else begin
                r_slot     <= slot_ext[SLOT_OUT_W-1:0];
                r_hit      <= 1'b0;
                r_ev_valid <= (victim_tex != '0);
                r_ev_tex   <= victim_tex;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_slot_index      = r_slot;
    assign o_hit             = r_hit;
    assign o_evicted_valid   = r_ev_valid;
    assign o_evicted_texture = r_ev_tex;

endmodule

/* hdl/tsr_slot_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_slot_table
// Texture held per slot, parallel match against the request and the
// read and refill of the evicted slot.
// ----------------------------------------------------------------------------
module tsr_slot_table #(
    parameter int NUM_SLOTS = tsr_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tsr_pkg::TEX_W-1:0] i_texture_id,
    input  logic [IDX_W-1:0]          i_victim,
    input  tsr_pkg::t_upd_ctrl        i_upd,
    output logic                      o_hit,
    output logic [IDX_W-1:0]          o_found,
    output logic [tsr_pkg::TEX_W-1:0] o_victim_texture
);
    import tsr_pkg::*;

    logic [TEX_W-1:0] r_contents [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] match;

    always_comb begin
        o_hit   = 1'b0;
        o_found = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            match[s] = (r_contents[s] == i_texture_id);
        end
        // lowest matching slot wins
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (match[s]) begin
                o_hit   = 1'b1;
                o_found = IDX_W'(s);
            end
        end
    end

    assign o_victim_texture = r_contents[i_victim];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_contents[s] <= '0;
            end
        end else if (i_upd.en && !i_upd.hit) begin
            r_contents[i_victim] <= i_texture_id;
        end
    end

endmodule

/* hdl/tsr_priority_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_priority_list
// Priority order of the slots: transpose on a hit, move to front on a miss.
// ----------------------------------------------------------------------------
module tsr_priority_list #(
    parameter int NUM_SLOTS = tsr_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsr_pkg::t_upd_ctrl i_upd,
    input  logic [IDX_W-1:0]   i_slot,
    output logic [IDX_W-1:0]   o_victim
);
    import tsr_pkg::*;

    logic [IDX_W-1:0]     r_order [NUM_SLOTS];
    logic [IDX_W-1:0]     n_order [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] at_place;

    assign o_victim = r_order[NUM_SLOTS-1];

    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            at_place[p] = (r_order[p] == i_slot);
        end
        for (int p = 0; p < NUM_SLOTS; p++) begin
            n_order[p] = r_order[p];
            if (i_upd.hit) begin
                if (p < NUM_SLOTS - 1) begin
                    if (at_place[p+1]) begin
                        n_order[p] = r_order[p+1];
                    end
                end
                if (p > 0) begin
                    if (at_place[p]) begin
                        n_order[p] = r_order[p-1];
                    end
                end
            end else if (p == 0) begin
                n_order[p] = r_order[NUM_SLOTS-1];
            end else begin
                n_order[p] = r_order[p-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_SLOTS; p++) begin
                r_order[p] <= IDX_W'(p);
            end
        end else if (i_upd.en) begin
            for (int p = 0; p < NUM_SLOTS; p++) begin
                r_order[p] <= n_order[p];
            end
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the texture slot replacement unit.
// Bind requests are fed from a queue in random bursts and gaps. Every input
// transfer is run through a local model of the slot table and the transpose
// priority order. The predicted result is compared field by field with each
// output transfer, which is taken under a changing stall pattern that
// includes long hold-offs.
// ----------------------------------------------------------------------------
module tb;
    import tsr_pkg::*;

    localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;
    localparam int POOL_SZ    = 32;
    localparam int N_RANDOM   = 1080;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  hit;
        logic                  evicted_valid;
        logic [TEX_W-1:0]      evicted_texture;
    } t_bind_result;

    typedef struct {
        logic [TEX_W-1:0] texture_id;
        bit               wait_drain;
    } t_bind_req;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [TEX_W-1:0]      i_texture_id = '0;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic                  o_hit;
    logic                  o_evicted_valid;
    logic [TEX_W-1:0]      o_evicted_texture;

    t_bind_req        bind_queue[$];
    t_bind_result     pending_results[$];
    logic [TEX_W-1:0] slot_tex[NUM_SLOTS];
    int               rank_slot[NUM_SLOTS];

    bit       in_took = 1'b0;
    int       n_accepted = 0;
    int       n_errors = 0;
    int       idle_cycles = 0;
    int       gap_left = 0;
    int       burst_left = 1;
    int       hold_left = 0;
    int       hold_mark = 300;
    int       stall_cnt = 0;
    t_rx_mode stall_mode = RX_FREE;

    texture_slot_replacement_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_texture_id      (i_texture_id),
        .o_stall           (o_stall),
        .o_valid           (o_valid),
        .o_slot_index      (o_slot_index),
        .o_hit             (o_hit),
        .o_evicted_valid   (o_evicted_valid),
        .o_evicted_texture (o_evicted_texture),
        .i_stall           (i_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // slot table and transpose order, advanced once per bind request with a nonzero id
    function automatic t_bind_result predict_bind(logic [TEX_W-1:0] id);
        t_bind_result r;
        int           found;
        int           pos;
        int           victim;
        int           tmp;
        r     = '0;
        found = -1;
        pos   = 0;
        if (id == '0) begin
            return r;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (found < 0 && slot_tex[s] == id) begin
                found = s;
            end
        end
        if (found >= 0) begin
            for (int p = NUM_SLOTS - 1; p >= 0; p--) begin
                if (rank_slot[p] == found) begin
                    pos = p;
                end
            end
            if (pos > 0) begin
                tmp              = rank_slot[pos - 1];
                rank_slot[pos - 1] = rank_slot[pos];
                rank_slot[pos]   = tmp;
            end
            r.slot_index = found[SLOT_OUT_W-1:0];
            r.hit        = 1'b1;
            return r;
        end
        victim            = rank_slot[NUM_SLOTS - 1];
        r.slot_index      = victim[SLOT_OUT_W-1:0];
        r.evicted_texture = slot_tex[victim];
        r.evicted_valid   = (slot_tex[victim] != '0);
        slot_tex[victim]  = id;
        for (int p = NUM_SLOTS - 1; p > 0; p--) begin
            rank_slot[p] = rank_slot[p - 1];
        end
        rank_slot[0] = victim;
        return r;
    endfunction

    function automatic void queue_bind(logic [TEX_W-1:0] id, bit drain);
        bind_queue.push_back(t_bind_req'{id, drain});
    endfunction

    function automatic logic [TEX_W-1:0] fresh_id();
        logic [TEX_W-1:0] v;
        v = $urandom();
        return (v == '0) ? 32'h1 : v;
    endfunction

    function automatic void check_field(string name, logic [TEX_W-1:0] want,
                                        logic [TEX_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // monitor: outputs are checked before the new input transfer is predicted
    always @(posedge i_clk) begin
        t_bind_result want;
        bit           out_took;
        if (!i_rst_n) begin
            in_took = 1'b0;
        end else begin
            in_took  = i_valid && !o_stall;
            out_took = o_valid && !i_stall;
            if (out_took) begin
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $error("unexpected result transfer, slot_index %0d", o_slot_index);
                end else begin
                    want = pending_results.pop_front();
                    check_field("slot_index", TEX_W'(want.slot_index), TEX_W'(o_slot_index));
                    check_field("hit", TEX_W'(want.hit), TEX_W'(o_hit));
                    check_field("evicted_valid", TEX_W'(want.evicted_valid),
                                TEX_W'(o_evicted_valid));
                    check_field("evicted_texture", want.evicted_texture, o_evicted_texture);
                end
            end
            if (in_took) begin
                pending_results.push_back(predict_bind(i_texture_id));
                n_accepted++;
            end
            idle_cycles = (in_took || out_took) ? 0 : idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // sender: bursts and gaps, a marked request waits until all results are back
    always @(negedge i_clk) begin
        t_bind_req req;
        logic      offer;
        offer = i_valid && !in_took;
        if (i_rst_n && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (bind_queue.size() != 0 &&
                         !(bind_queue[0].wait_drain && pending_results.size() != 0)) begin
                req = bind_queue.pop_front();
                i_texture_id <= req.texture_id;
                offer = 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= offer;
    end

    // receiver: stall mode is redrawn at random, long hold-offs at set marks
    always @(negedge i_clk) begin
        logic stall_next;
        stall_cnt++;
        if (stall_cnt % 64 == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 3));
        end
        if (hold_left == 0 && n_accepted >= hold_mark) begin
            hold_left = HOLD_LEN;
            hold_mark = (hold_mark < 800) ? 800 : 2 ** 30;
        end
        if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                RX_FREE:     stall_next = 1'b0;
                RX_LIGHT:    stall_next = ($urandom_range(0, 2) == 0);
                RX_HEAVY:    stall_next = ($urandom_range(0, 2) != 0);
                RX_PERIODIC: stall_next = (stall_cnt % 4) != 0;
                default:     stall_next = 1'b0;
            endcase
        end
        i_stall <= stall_next;
    end

    initial begin
        logic [TEX_W-1:0] pool[POOL_SZ];
        logic [TEX_W-1:0] id;
        logic [TEX_W-1:0] last_id;
        int               pool_used;
        int               pick;
        int               n_total;

        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_tex[s]  = '0;
            rank_slot[s] = s;
        end

        // zero id, extremes, hits below first place, fill, first-place hit, an eviction
        queue_bind(32'h0, 1'b0);
        queue_bind(32'h1, 1'b0);
        queue_bind(32'hFFFF_FFFF, 1'b0);
        queue_bind(32'h8000_0000, 1'b0);
        queue_bind(32'h1, 1'b0);
        queue_bind(32'hFFFF_FFFF, 1'b0);
        queue_bind(32'h5555_5555, 1'b0);
        queue_bind(32'hAAAA_AAAA, 1'b0);
        for (int k = 0; k < 11; k++) begin
            queue_bind(32'h0000_1000 + k, 1'b0);
        end
        queue_bind(32'h0000_100A, 1'b0);
        queue_bind(32'h7FFF_FFFF, 1'b0);
        queue_bind(32'h0, 1'b0);
        queue_bind(32'h8000_0000, 1'b0);
        queue_bind(32'h0000_100A, 1'b0);

        for (int p = 0; p < POOL_SZ; p++) begin
            pool[p] = fresh_id();
        end
        last_id   = 32'h1;
        pool_used = 20;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) begin
                pool_used = $urandom_range(8, POOL_SZ);
                for (int r = 0; r < 4; r++) begin
                    pool[$urandom_range(0, POOL_SZ - 1)] = fresh_id();
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                id = '0;
            end else if (pick < 20) begin
                id = fresh_id();
            end else if (pick < 32) begin
                id = last_id;
            end else begin
                id = pool[$urandom_range(0, pool_used - 1)];
            end
            queue_bind(id, k == 0 || k == 600);
            last_id = id;
        end
        n_total = bind_queue.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (n_accepted < n_total) @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
